// ===== rtl/core/eqro_pkg.sv =====
// Shared types and constants for the event queue with overflow recovery ring.
package eqro_pkg;

	// Ring depths; each ring holds one entry fewer than its depth
	localparam int unsigned MAIN_DEPTH  = 256;
	localparam int unsigned SPILL_DEPTH = 16;
	localparam int unsigned MAIN_AW     = $clog2(MAIN_DEPTH);
	localparam int unsigned SPILL_AW    = $clog2(SPILL_DEPTH);

	// Request codes
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// Event kinds
	localparam logic [2:0] KIND_KEY_DOWN   = 3'd0;
	localparam logic [2:0] KIND_KEY_UP     = 3'd1;
	localparam logic [2:0] KIND_MOUSE_DOWN = 3'd2;
	localparam logic [2:0] KIND_MOUSE_UP   = 3'd3;

	// Modifier identifiers
	localparam logic [2:0] MOD_NONE          = 3'd0;
	localparam logic [2:0] MOD_CONTROL_LEFT  = 3'd1;
	localparam logic [2:0] MOD_CONTROL_RIGHT = 3'd2;
	localparam logic [2:0] MOD_SHIFT_LEFT    = 3'd3;
	localparam logic [2:0] MOD_SHIFT_RIGHT   = 3'd4;

	// One stored event as it sits in either ring
	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] key;
		logic [31:0] stamp;
		logic [63:0] seq;
	} event_t;

	localparam int unsigned EVENT_W = $bits(event_t);

endpackage

// ===== rtl/core/eqro_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module eqro_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/event_queue_with_release_overflow_top.sv =====
// Top level of the event queue with main ring and overflow recovery ring.
//
// A request is taken when start is high and busy is low. A push is answered
// directly: its result appears with done in the next cycle and another request
// may follow at once. A pop passes through a compare state: the heads of both
// rings are read from their memories, whose read data is registered, busy is
// high for the compare cycle, and the result appears with done in the cycle after that.
// Every request gives exactly one result, on the result ports for one cycle
// only; the receiver cannot hold it off. Each push is stamped with a 64-bit
// running sequence number; when the main ring is full only key-up and
// mouse-up events go to the recovery ring, and any push that finds no room
// (including a release that finds the recovery ring full) is counted as
// dropped. The ring memories need no clearing after reset.
module event_queue_with_release_overflow_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [2:0]  event_kind,
	input  logic [15:0] key_code,
	input  logic [2:0]  modifier_id,
	input  logic [31:0] time_stamp,
	output logic        done,
	output logic        ok,
	output logic [2:0]  out_kind,
	output logic [15:0] out_key,
	output logic [31:0] out_time,
	output logic [63:0] out_sequence,
	output logic        from_recovery,
	output logic        control_down,
	output logic        shift_down,
	output logic [31:0] drop_count
);

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	state_t state_q;

	logic [eqro_pkg::MAIN_AW-1:0]  main_wp_q, main_rp_q, main_wp_inc, main_rp_inc;
	logic [eqro_pkg::SPILL_AW-1:0] spill_wp_q, spill_rp_q, spill_wp_inc, spill_rp_inc;
	logic [63:0] seq_q;
	logic [1:0]  ctrl_q, shift_q, ctrl_nxt, shift_nxt;
	logic [31:0] drop_q;

	logic accept, is_push, main_full, spill_full, is_release;
	logic main_we, spill_we, main_nonempty, spill_nonempty, take_spill;
	eqro_pkg::event_t wr_event, main_head, spill_head;

	// Handshake
	assign busy    = (state_q == ST_POP);
	assign accept  = start && !busy;
	assign is_push = (req_type == eqro_pkg::REQ_PUSH);

	// Pointer increments with wrap at the ring depth
	assign main_wp_inc  = (main_wp_q == eqro_pkg::MAIN_AW'(eqro_pkg::MAIN_DEPTH - 1))
		? '0 : main_wp_q + 1'b1;
	assign main_rp_inc  = (main_rp_q == eqro_pkg::MAIN_AW'(eqro_pkg::MAIN_DEPTH - 1))
		? '0 : main_rp_q + 1'b1;
	assign spill_wp_inc = (spill_wp_q == eqro_pkg::SPILL_AW'(eqro_pkg::SPILL_DEPTH - 1))
		? '0 : spill_wp_q + 1'b1;
	assign spill_rp_inc = (spill_rp_q == eqro_pkg::SPILL_AW'(eqro_pkg::SPILL_DEPTH - 1))
		? '0 : spill_rp_q + 1'b1;

	// Push routing: main ring first, release events spill over
	assign main_full  = (main_wp_inc == main_rp_q);
	assign spill_full = (spill_wp_inc == spill_rp_q);
	assign is_release = (event_kind == eqro_pkg::KIND_KEY_UP) ||
		(event_kind == eqro_pkg::KIND_MOUSE_UP);
	assign main_we  = accept && is_push && !main_full;
	assign spill_we = accept && is_push && main_full && is_release && !spill_full;

	assign wr_event = '{kind: event_kind, key: key_code, stamp: time_stamp, seq: seq_q};

	// Update modifier bits on key down/up
	always_comb begin
		ctrl_nxt  = ctrl_q;
		shift_nxt = shift_q;
		if (event_kind == eqro_pkg::KIND_KEY_DOWN) begin
			case (modifier_id)
				eqro_pkg::MOD_CONTROL_LEFT:  ctrl_nxt[0]  = 1'b1;
				eqro_pkg::MOD_CONTROL_RIGHT: ctrl_nxt[1]  = 1'b1;
				eqro_pkg::MOD_SHIFT_LEFT:    shift_nxt[0] = 1'b1;
				eqro_pkg::MOD_SHIFT_RIGHT:   shift_nxt[1] = 1'b1;
				default: ;
			endcase
		end else if (event_kind == eqro_pkg::KIND_KEY_UP) begin
			case (modifier_id)
				eqro_pkg::MOD_CONTROL_LEFT:  ctrl_nxt[0]  = 1'b0;
				eqro_pkg::MOD_CONTROL_RIGHT: ctrl_nxt[1]  = 1'b0;
				eqro_pkg::MOD_SHIFT_LEFT:    shift_nxt[0] = 1'b0;
				eqro_pkg::MOD_SHIFT_RIGHT:   shift_nxt[1] = 1'b0;
				default: ;
			endcase
		end
	end

	// Ring memories, read continuously at the head pointers
	eqro_ram #(
		.WIDTH(eqro_pkg::EVENT_W),
		.DEPTH(eqro_pkg::MAIN_DEPTH)
	) u_main_ram (
		.clk   (clk),
		.we    (main_we),
		.waddr (main_wp_q),
		.wdata (wr_event),
		.raddr (main_rp_q),
		.rdata (main_head)
	);

	eqro_ram #(
		.WIDTH(eqro_pkg::EVENT_W),
		.DEPTH(eqro_pkg::SPILL_DEPTH)
	) u_spill_ram (
		.clk   (clk),
		.we    (spill_we),
		.waddr (spill_wp_q),
		.wdata (wr_event),
		.raddr (spill_rp_q),
		.rdata (spill_head)
	);

	// Pick the older head
	assign main_nonempty  = (main_rp_q != main_wp_q);
	assign spill_nonempty = (spill_rp_q != spill_wp_q);
	assign take_spill     = spill_nonempty &&
		(!main_nonempty || (spill_head.seq < main_head.seq));

	// Hold state, pointers, counters and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			main_wp_q     <= '0;
			main_rp_q     <= '0;
			spill_wp_q    <= '0;
			spill_rp_q    <= '0;
			seq_q         <= '0;
			ctrl_q        <= '0;
			shift_q       <= '0;
			drop_q        <= '0;
			done          <= 1'b0;
			ok            <= 1'b0;
			out_kind      <= '0;
			out_key       <= '0;
			out_time      <= '0;
			out_sequence  <= '0;
			from_recovery <= 1'b0;
			control_down  <= 1'b0;
			shift_down    <= 1'b0;
			drop_count    <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_push) begin
						seq_q         <= seq_q + 64'd1;
						ctrl_q        <= ctrl_nxt;
						shift_q       <= shift_nxt;
						done          <= 1'b1;
						ok            <= main_we || spill_we;
						out_kind      <= '0;
						out_key       <= '0;
						out_time      <= '0;
						out_sequence  <= '0;
						from_recovery <= 1'b0;
						control_down  <= |ctrl_nxt;
						shift_down    <= |shift_nxt;
						if (main_we) begin
							main_wp_q <= main_wp_inc;
						end
						if (spill_we) begin
							spill_wp_q <= spill_wp_inc;
						end
						if (!main_we && !spill_we) begin
							drop_q     <= drop_q + 32'd1;
							drop_count <= drop_q + 32'd1;
						end else begin
							drop_count <= drop_q;
						end
					end else if (accept) begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					state_q      <= ST_IDLE;
					done         <= 1'b1;
					control_down <= |ctrl_q;
					shift_down   <= |shift_q;
					drop_count   <= drop_q;
					if (take_spill) begin
						spill_rp_q    <= spill_rp_inc;
						ok            <= 1'b1;
						out_kind      <= spill_head.kind;
						out_key       <= spill_head.key;
						out_time      <= spill_head.stamp;
						out_sequence  <= spill_head.seq;
						from_recovery <= 1'b1;
					end else if (main_nonempty) begin
						main_rp_q     <= main_rp_inc;
						ok            <= 1'b1;
						out_kind      <= main_head.kind;
						out_key       <= main_head.key;
						out_time      <= main_head.stamp;
						out_sequence  <= main_head.seq;
						from_recovery <= 1'b0;
					end else begin
						ok            <= 1'b0;
						out_kind      <= '0;
						out_key       <= '0;
						out_time      <= '0;
						out_sequence  <= '0;
						from_recovery <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A pop compare cycle always ends in a result
	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |=> (done && (state_q == ST_IDLE)))
		else $error("pop compare cycle did not produce a result");

	// A recovery-ring result is always a successful pop
	a_rec_ok: assert property (@(posedge clk) disable iff (!arst_n)
		from_recovery |-> ok)
		else $error("recovery result without ok");

	// Write pointers move only on an accepted push
	a_wp_move: assert property (@(posedge clk) disable iff (!arst_n)
		((main_wp_q != $past(main_wp_q)) || (spill_wp_q != $past(spill_wp_q)))
		|-> $past(accept && is_push))
		else $error("write pointer moved without a push");

	// Never write both rings with one push
	a_one_ring: assert property (@(posedge clk) disable iff (!arst_n)
		!(main_we && spill_we))
		else $error("push written to both rings");

	// Read pointers move only at the end of a pop
	a_rp_move: assert property (@(posedge clk) disable iff (!arst_n)
		((main_rp_q != $past(main_rp_q)) || (spill_rp_q != $past(spill_rp_q)))
		|-> ($past(state_q == ST_POP) && done && ok))
		else $error("read pointer moved outside a pop");

endmodule
